// ===== rtl/sdi_pkg.sv =====
// Package for the SD card SPI-mode init sequencer: item structs, phase enum,
// result codes and command frames. No dependencies.
package sdi_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        cs_active;
      logic        done_res;
      logic [2:0]  init_status;
      logic [1:0]  card_version;
      logic        high_capacity;
      logic [31:0] ocr_value;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] read_limit;
      logic [3:0] cmd0_tries;
   } cfg_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_DUMMY,
      PH_C0_SEND, PH_C0_POLL, PH_C0_TRAIL_OK, PH_C0_TRAIL_FAIL,
      PH_C8_SEND, PH_C8_POLL, PH_C8_DATA, PH_C8_TRAIL,
      PH_OA_SEND, PH_OA_POLL, PH_OA_DATA, PH_OA_TRAIL,
      PH_C55_SEND, PH_C55_POLL, PH_C55_TRAIL,
      PH_A41_SEND, PH_A41_POLL, PH_A41_TRAIL_AGAIN, PH_A41_TRAIL_READY,
      PH_OB_SEND, PH_OB_POLL, PH_OB_DATA, PH_OB_TRAIL,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY, ST_SUCCESS, ST_CMD0_FAIL, ST_CMD8_FAIL,
      ST_OCR_FAIL, ST_CMD55_FAIL, ST_ACMD41_FAIL
   } status_type;

   localparam logic [1:0] VER_UNKNOWN = 2'd0;
   localparam logic [1:0] VER_V1      = 2'd1;
   localparam logic [1:0] VER_V2      = 2'd2;

   localparam logic CSR_IDX_READ_LIMIT = 1'b0;
   localparam logic CSR_IDX_CMD0_TRIES = 1'b1;

   localparam logic [7:0] READ_LIMIT_RESET = 8'd8;
   localparam logic [3:0] CMD0_TRIES_RESET = 4'd10;

   localparam logic [7:0] FILL_BYTE  = 8'hFF;
   localparam logic [7:0] R1_IDLE    = 8'h01;
   localparam logic [7:0] R1_READY   = 8'h00;
   localparam logic [7:0] R1_ILL_A   = 8'h05;
   localparam logic [7:0] R1_ILL_B   = 8'h0D;
   localparam logic [7:0] CHECK_ECHO = 8'hAA;
   localparam logic [7:0] VHS_ECHO   = 8'h01;
   localparam logic [7:0] OCR_BYTE1  = 8'hFF;
   localparam logic [7:0] OCR_BYTE2  = 8'h80;

   localparam int CMD_LEN  = 6;
   localparam int DATA_LEN = 4;

   // six-byte command frames, first byte sent in the top byte
   localparam logic [47:0] CMD0_FRAME   = 48'h40_00_00_00_00_95;
   localparam logic [47:0] CMD8_FRAME   = 48'h48_00_00_01_AA_87;
   localparam logic [47:0] CMD58_FRAME  = 48'h7A_00_00_00_00_FD;
   localparam logic [47:0] CMD55_FRAME  = 48'h77_00_00_00_00_65;
   localparam logic [47:0] ACMD41_FRAME = 48'h69_40_00_00_00_77;

endpackage

// ===== rtl/sdi_csr.sv =====
// Configuration registers of the SD init sequencer.
// Depends on sdi_pkg.
module sdi_csr
   import sdi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_limit <= READ_LIMIT_RESET;
         cfg_ff.cmd0_tries <= CMD0_TRIES_RESET;
      end else if (csr_valid && csr_ready && csr_index[1] == 1'b0) begin
         if (csr_index[0] == CSR_IDX_READ_LIMIT) begin
            cfg_ff.read_limit <= csr_wdata;
         end else if (csr_index[0] == CSR_IDX_CMD0_TRIES) begin
            cfg_ff.cmd0_tries <= csr_wdata[3:0];
         end
      end
   end

endmodule

// ===== rtl/sdi_core.sv =====
// Sequencer state and per-byte next-state logic of the SD init sequencer.
// Depends on sdi_pkg.
module sdi_core
   import sdi_pkg::*;
#(
   parameter int DUMMY_BYTES = 20
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam int BIDX_W = $clog2(DUMMY_BYTES + 1);

   phase_type     phase_ff, phase_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic [7:0]    poll_ff, poll_in;
   logic [3:0]    retry_ff, retry_in;
   logic [1:0]    ver_ff, ver_in;
   logic          cap_ff, cap_in;
   logic [31:0]   ocr_ff, ocr_in;
   status_type    status_ff, status_in;
   logic [31:0]   gather_ff, gather_in;

   function automatic logic [7:0] cmd_byte(input phase_type ph, input logic [2:0] idx);
      logic [47:0] frame;
      logic [2:0]  sel;
      begin
         unique case (ph)
            PH_C0_SEND:               frame = CMD0_FRAME;
            PH_C8_SEND:               frame = CMD8_FRAME;
            PH_OA_SEND, PH_OB_SEND:   frame = CMD58_FRAME;
            PH_C55_SEND:              frame = CMD55_FRAME;
            default:                  frame = ACMD41_FRAME;
         endcase
         sel = 3'd5 - idx;
         cmd_byte = frame[{sel, 3'b000} +: 8];
      end
   endfunction

   function automatic phase_type poll_of(input phase_type ph);
      begin
         unique case (ph)
            PH_C0_SEND:  poll_of = PH_C0_POLL;
            PH_C8_SEND:  poll_of = PH_C8_POLL;
            PH_OA_SEND:  poll_of = PH_OA_POLL;
            PH_OB_SEND:  poll_of = PH_OB_POLL;
            PH_C55_SEND: poll_of = PH_C55_POLL;
            default:     poll_of = PH_A41_POLL;
         endcase
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bidx_ff   <= '0;
         poll_ff   <= '0;
         retry_ff  <= '0;
         ver_ff    <= VER_UNKNOWN;
         cap_ff    <= 1'b0;
         ocr_ff    <= '0;
         status_ff <= ST_BUSY;
         gather_ff <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         bidx_ff   <= bidx_in;
         poll_ff   <= poll_in;
         retry_ff  <= retry_in;
         ver_ff    <= ver_in;
         cap_ff    <= cap_in;
         ocr_ff    <= ocr_in;
         status_ff <= status_in;
         gather_ff <= gather_in;
      end
   end

   logic [7:0]        rx;
   logic [7:0]        poll_inc;
   logic [3:0]        retry_inc;
   logic [BIDX_W-1:0] bidx_inc;
   logic [31:0]       gather_nx;
   logic              illegal;
   logic              matched;
   logic              no_ans;
   phase_type         nap;
   logic              is_send;
   logic              is_trail;

   always_comb begin
      rx        = item.rx_byte;
      poll_inc  = poll_ff + 8'd1;
      retry_inc = retry_ff + 4'd1;
      bidx_inc  = bidx_ff + BIDX_W'(1);
      gather_nx = {gather_ff[23:0], rx};
      illegal   = (rx == R1_ILL_A) || (rx == R1_ILL_B);
      matched   = 1'b1;
      no_ans    = 1'b0;
      nap       = phase_ff;

      phase_in  = phase_ff;
      bidx_in   = bidx_ff;
      poll_in   = poll_ff;
      retry_in  = retry_ff;
      ver_in    = ver_ff;
      cap_in    = cap_ff;
      ocr_in    = ocr_ff;
      status_in = status_ff;
      gather_in = gather_ff;

      if (!item.req_type) begin
         phase_in  = PH_DUMMY;
         bidx_in   = '0;
         poll_in   = '0;
         retry_in  = '0;
         ver_in    = VER_UNKNOWN;
         cap_in    = 1'b0;
         ocr_in    = '0;
         status_in = ST_BUSY;
         gather_in = '0;
      end else begin
         unique case (phase_ff)
            PH_DUMMY: begin
               bidx_in = bidx_inc;
               if (bidx_inc >= BIDX_W'(DUMMY_BYTES)) begin
                  retry_in = '0;
                  if (cfg.cmd0_tries == 4'd0) begin
                     phase_in = PH_C0_TRAIL_FAIL;
                  end else begin
                     phase_in = PH_C0_SEND;
                     bidx_in  = '0;
                     poll_in  = '0;
                  end
               end
            end
            PH_C0_SEND, PH_C8_SEND, PH_OA_SEND, PH_OB_SEND, PH_C55_SEND,
            PH_A41_SEND: begin
               bidx_in = bidx_inc;
               if (bidx_inc >= BIDX_W'(CMD_LEN)) begin
                  poll_in = '0;
                  if (cfg.read_limit == 8'd0) begin
                     no_ans = 1'b1;
                     nap    = poll_of(phase_ff);
                  end else begin
                     phase_in = poll_of(phase_ff);
                  end
               end
            end
            PH_C0_POLL: begin
               if (rx == R1_IDLE) phase_in = PH_C0_TRAIL_OK;
               else matched = 1'b0;
            end
            PH_C8_POLL: begin
               if (rx == R1_IDLE) begin
                  phase_in  = PH_C8_DATA;
                  bidx_in   = '0;
                  gather_in = '0;
               end else if (illegal) begin
                  ver_in   = VER_V1;
                  phase_in = PH_C8_TRAIL;
               end else begin
                  matched = 1'b0;
               end
            end
            PH_OA_POLL, PH_OB_POLL: begin
               if (illegal && ver_ff == VER_V1) begin
                  status_in = ST_OCR_FAIL;
                  phase_in  = PH_DONE;
               end else if (rx == ((phase_ff == PH_OA_POLL) ? R1_IDLE : R1_READY)) begin
                  phase_in  = (phase_ff == PH_OA_POLL) ? PH_OA_DATA : PH_OB_DATA;
                  bidx_in   = '0;
                  gather_in = '0;
               end else begin
                  matched = 1'b0;
               end
            end
            PH_C55_POLL: begin
               if (rx == R1_IDLE || rx == R1_READY) phase_in = PH_C55_TRAIL;
               else matched = 1'b0;
            end
            PH_A41_POLL: begin
               if (rx == R1_IDLE) phase_in = PH_A41_TRAIL_AGAIN;
               else if (rx == R1_READY) phase_in = PH_A41_TRAIL_READY;
               else matched = 1'b0;
            end
            PH_C8_DATA, PH_OA_DATA, PH_OB_DATA: begin
               gather_in = gather_nx;
               bidx_in   = bidx_inc;
               if (bidx_inc >= BIDX_W'(DATA_LEN)) begin
                  if (phase_ff == PH_C8_DATA) begin
                     if (gather_nx[15:8] == VHS_ECHO && gather_nx[7:0] == CHECK_ECHO) begin
                        ver_in   = VER_V2;
                        phase_in = PH_C8_TRAIL;
                     end else begin
                        status_in = ST_CMD8_FAIL;
                        phase_in  = PH_DONE;
                     end
                  end else begin
                     ocr_in = gather_nx;
                     if (gather_nx[23:16] == OCR_BYTE1 && gather_nx[15:8] == OCR_BYTE2) begin
                        phase_in = (phase_ff == PH_OA_DATA) ? PH_OA_TRAIL : PH_OB_TRAIL;
                     end else begin
                        status_in = ST_OCR_FAIL;
                        phase_in  = PH_DONE;
                     end
                  end
               end
            end
            PH_C0_TRAIL_OK: begin
               phase_in = PH_C8_SEND;
               bidx_in  = '0;
               poll_in  = '0;
            end
            PH_C0_TRAIL_FAIL: begin
               status_in = ST_CMD0_FAIL;
               phase_in  = PH_DONE;
            end
            PH_C8_TRAIL: begin
               phase_in = PH_OA_SEND;
               bidx_in  = '0;
               poll_in  = '0;
            end
            PH_OA_TRAIL, PH_A41_TRAIL_AGAIN: begin
               phase_in = PH_C55_SEND;
               bidx_in  = '0;
               poll_in  = '0;
            end
            PH_C55_TRAIL: begin
               phase_in = PH_A41_SEND;
               bidx_in  = '0;
               poll_in  = '0;
            end
            PH_A41_TRAIL_READY: begin
               if (ver_ff == VER_V2) begin
                  phase_in = PH_OB_SEND;
                  bidx_in  = '0;
                  poll_in  = '0;
               end else begin
                  cap_in    = 1'b0;
                  status_in = ST_SUCCESS;
                  phase_in  = PH_DONE;
               end
            end
            PH_OB_TRAIL: begin
               cap_in    = ocr_ff[30];
               status_in = ST_SUCCESS;
               phase_in  = PH_DONE;
            end
            default: begin
               // idle or finished: exchanges leave everything as it is
            end
         endcase

         if (!matched) begin
            poll_in = poll_inc;
            if (poll_inc >= cfg.read_limit) no_ans = 1'b1;
         end

         if (no_ans) begin
            unique case (nap)
               PH_C0_POLL: begin
                  retry_in = retry_inc;
                  if (retry_inc < cfg.cmd0_tries) begin
                     phase_in = PH_C0_SEND;
                     bidx_in  = '0;
                     poll_in  = '0;
                  end else begin
                     phase_in = PH_C0_TRAIL_FAIL;
                  end
               end
               PH_C8_POLL: begin
                  status_in = ST_CMD8_FAIL;
                  phase_in  = PH_DONE;
               end
               PH_OA_POLL, PH_OB_POLL: begin
                  status_in = ST_OCR_FAIL;
                  phase_in  = PH_DONE;
               end
               PH_C55_POLL: begin
                  status_in = ST_CMD55_FAIL;
                  phase_in  = PH_DONE;
               end
               default: begin
                  status_in = ST_ACMD41_FAIL;
                  phase_in  = PH_DONE;
               end
            endcase
         end
      end

      // result for the byte that follows, from the updated state
      is_send = (phase_in == PH_C0_SEND) || (phase_in == PH_C8_SEND) ||
                (phase_in == PH_OA_SEND) || (phase_in == PH_OB_SEND) ||
                (phase_in == PH_C55_SEND) || (phase_in == PH_A41_SEND);
      is_trail = (phase_in == PH_DUMMY) || (phase_in == PH_C0_TRAIL_OK) ||
                 (phase_in == PH_C0_TRAIL_FAIL) || (phase_in == PH_C8_TRAIL) ||
                 (phase_in == PH_OA_TRAIL) || (phase_in == PH_C55_TRAIL) ||
                 (phase_in == PH_A41_TRAIL_AGAIN) || (phase_in == PH_A41_TRAIL_READY) ||
                 (phase_in == PH_OB_TRAIL);

      result.tx_valid  = 1'b0;
      result.tx_byte   = 8'h00;
      result.cs_active = 1'b0;
      if (is_send) begin
         result.tx_valid  = 1'b1;
         result.cs_active = 1'b1;
         result.tx_byte   = (bidx_in < BIDX_W'(CMD_LEN)) ? cmd_byte(phase_in, bidx_in[2:0])
                                                         : FILL_BYTE;
      end else if (is_trail) begin
         result.tx_valid = 1'b1;
         result.tx_byte  = FILL_BYTE;
      end else if (phase_in != PH_IDLE && phase_in != PH_DONE) begin
         result.tx_valid  = 1'b1;
         result.cs_active = 1'b1;
         result.tx_byte   = FILL_BYTE;
      end
      result.done_res      = (phase_in == PH_DONE);
      result.init_status   = status_in;
      result.card_version  = ver_in;
      result.high_capacity = cap_in;
      result.ocr_value     = ocr_in;
   end

endmodule

// ===== rtl/sd_spi_init_sequencer_top.sv =====
// Top level of the SD card SPI-mode init sequencer: input register, result
// register, configuration registers and the sequencer core. Depends on sdi_pkg.
//
// Host-side SPI-mode SD card power-up sequencer. Send a start item (req_type 0),
// then one item per completed SPI byte exchange carrying the received byte; each
// item yields one result with the next byte to shift out, the chip-select level
// and the status so far. One item is taken every clock cycle while no result is held
// by rsp_stall. An accepted item waits in the input register until the result
// register is free; the sequencer state then advances and the result register loads,
// raising rsp_valid. While a result is held by rsp_stall the input register still
// takes one more item, then req_stall stays high until the result is taken. Write
// the response poll limit (index 0) and go-idle try count (index 1) only while idle.
module sd_spi_init_sequencer_top
   import sdi_pkg::*;
#(
   parameter int DUMMY_BYTES = 20
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   logic         in_vld_ff;
   req_item_type in_item_ff;
   logic         rsp_vld_ff;
   rsp_item_type rsp_item_ff;
   logic         out_free;
   logic         fire;
   cfg_type      cfg;
   rsp_item_type result;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_item_ff;

   sdi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdi_core #(
      .DUMMY_BYTES (DUMMY_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   // result register: loaded on each processed item, emptied on a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= result;
      end
   end

endmodule
